// ===== rtl/bpc_pkg.sv =====
// Package for the button press classifier: event and mode codes, register
// indexes, fixed thresholds and the configuration struct.
// Used by every module of the block but bpc_checker; depends on nothing.
package bpc_pkg;

	localparam int unsigned TimeW    = 32;
	localparam int unsigned AnalogW  = 10;
	localparam int unsigned MsW      = 16;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned LadderN  = 4;

	localparam logic [AnalogW-1:0] LadderTol    = AnalogW'(15);
	localparam logic [AnalogW-1:0] AnalogRelLvl = AnalogW'(512);

	typedef enum logic [1:0] {
		MODE_DIGITAL   = 2'd0,
		MODE_THRESHOLD = 2'd1,
		MODE_LADDER    = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SWITCH_MODE   = 3'd0,
		REG_LADDER_A      = 3'd1,
		REG_LADDER_B      = 3'd2,
		REG_LADDER_C      = 3'd3,
		REG_LADDER_D      = 3'd4,
		REG_DOUBLE_WINDOW = 3'd5,
		REG_LONG_HOLD     = 3'd6,
		REG_RELEASE_GUARD = 3'd7
	} reg_idx_t;

	typedef logic [AnalogW-1:0] ladder_arr_t [LadderN];

	typedef struct packed {
		logic [1:0]     switch_mode;
		logic [MsW-1:0] double_window_ms;
		logic [MsW-1:0] long_hold_ms;
		logic [MsW-1:0] release_guard_ms;
	} timing_cfg_t;

endpackage

// ===== rtl/bpc_level.sv =====
// Decides whether the button counts as released for one poll.
// Depends on bpc_pkg for the mode codes and the analog thresholds.
module bpc_level (
	input  logic [1:0]                   switch_mode,
	input  bpc_pkg::ladder_arr_t         ladder,
	input  logic                         digital_level,
	input  logic [bpc_pkg::AnalogW-1:0]  analog_level,
	output logic                         released
);

	logic [bpc_pkg::LadderN-1:0] near;

	// Each ladder tap is an independent distance check.
	always_comb begin
		for (int i = 0; i < bpc_pkg::LadderN; i++) begin
			if (analog_level >= ladder[i]) begin
				near[i] = (analog_level - ladder[i]) < bpc_pkg::LadderTol;
			end else begin
				near[i] = (ladder[i] - analog_level) < bpc_pkg::LadderTol;
			end
		end
	end

	always_comb begin
		unique case (switch_mode)
			bpc_pkg::MODE_THRESHOLD: released = analog_level >= bpc_pkg::AnalogRelLvl;
			bpc_pkg::MODE_LADDER:    released = ~|near;
			// The unused mode code behaves like digital mode.
			default:                 released = digital_level;
		endcase
	end

endmodule

// ===== rtl/bpc_classify.sv =====
// Press state and event decision: previous level and three time stamps.
// Depends on bpc_pkg for the event codes and the timing struct.
module bpc_classify (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [bpc_pkg::TimeW-1:0]   now_ms,
	input  logic                        released,
	input  bpc_pkg::timing_cfg_t        tcfg,
	output bpc_pkg::event_t             press_event
);

	logic                      prev_released_q;
	logic [bpc_pkg::TimeW-1:0] pressed_since_q;
	logic [bpc_pkg::TimeW-1:0] single_press_q;
	logic [bpc_pkg::TimeW-1:0] last_action_q;

	logic                      prev_released_d;
	logic [bpc_pkg::TimeW-1:0] pressed_since_d;
	logic [bpc_pkg::TimeW-1:0] single_press_d;
	logic [bpc_pkg::TimeW-1:0] last_action_d;

	logic [bpc_pkg::TimeW-1:0] since_single;
	logic [bpc_pkg::TimeW-1:0] since_press;
	logic [bpc_pkg::TimeW-1:0] since_action;

	// Wrapping differences; a stamp that runs backward gives a large value.
	assign since_single = now_ms - single_press_q;
	assign since_press  = now_ms - pressed_since_q;
	assign since_action = now_ms - last_action_q;

	always_comb begin
		press_event     = bpc_pkg::EV_NONE;
		pressed_since_d = pressed_since_q;
		single_press_d  = single_press_q;
		last_action_d   = last_action_q;
		prev_released_d = released;
		if (!released) begin
			if (prev_released_q) begin
				pressed_since_d = now_ms;
				if (since_single < bpc_pkg::TimeW'(tcfg.double_window_ms)) begin
					last_action_d  = now_ms;
					single_press_d = '0;
					press_event    = bpc_pkg::EV_DOUBLE;
				end
			end else if (since_press >= bpc_pkg::TimeW'(tcfg.long_hold_ms)) begin
				// A zero stamp means the long press was already reported.
				if (pressed_since_q != '0) begin
					pressed_since_d = '0;
					press_event     = bpc_pkg::EV_LONG;
				end
				last_action_d = now_ms;
			end
		end else if (!prev_released_q &&
			since_action > bpc_pkg::TimeW'(tcfg.release_guard_ms)) begin
			last_action_d   = now_ms;
			pressed_since_d = '0;
			single_press_d  = now_ms;
			press_event     = bpc_pkg::EV_SINGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_released_q <= 1'b1;
			pressed_since_q <= '0;
			single_press_q  <= '0;
			last_action_q   <= '0;
		end else if (advance) begin
			prev_released_q <= prev_released_d;
			pressed_since_q <= pressed_since_d;
			single_press_q  <= single_press_d;
			last_action_q   <= last_action_d;
		end
	end

endmodule

// ===== rtl/button_press_classifier_core.sv =====
// Top level of the button press classifier: configuration registers, input
// register, result register and the two working units.
// Depends on bpc_pkg, bpc_level and bpc_classify.
//
// Each word on the input channel is one poll of a push button (time stamp in
// ms, digital level, 10-bit analog level) and yields exactly one result word,
// press_event: none, single, double or long press. A poll is first captured
// in an input register; once the result register is free or drains, the
// released decision and the press state update are done in one pass of logic
// and the event is loaded into the result register, which drives out_valid.
// A poll can be accepted in every clock cycle while in_ready is high, so the
// sustained rate is one poll per cycle when out_ready does not stall. The
// input register and the result register form a two-word buffer: a poll is
// still taken while a finished result waits, and in_ready drops only when
// both hold a word and out_ready is low. The configuration registers reset to
// digital mode, ladder values of zero, a 300 ms double-press window, a 500 ms
// long-hold time and a 200 ms release guard; they must be written only while
// no poll is in flight.
module button_press_classifier_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data,
	// Poll channel.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bpc_pkg::TimeW-1:0]     now_ms,
	input  logic                          digital_level,
	input  logic [bpc_pkg::AnalogW-1:0]   analog_level,
	// Event channel.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    press_event
);

	// Configuration registers.
	bpc_pkg::timing_cfg_t tcfg_q;
	bpc_pkg::ladder_arr_t ladder_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcfg_q.switch_mode      <= bpc_pkg::MODE_DIGITAL;
			tcfg_q.double_window_ms <= bpc_pkg::MsW'(300);
			tcfg_q.long_hold_ms     <= bpc_pkg::MsW'(500);
			tcfg_q.release_guard_ms <= bpc_pkg::MsW'(200);
			for (int i = 0; i < bpc_pkg::LadderN; i++) begin
				ladder_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpc_pkg::REG_SWITCH_MODE:   tcfg_q.switch_mode <= cfg_data[1:0];
				bpc_pkg::REG_LADDER_A:      ladder_q[0] <= cfg_data[bpc_pkg::AnalogW-1:0];
				bpc_pkg::REG_LADDER_B:      ladder_q[1] <= cfg_data[bpc_pkg::AnalogW-1:0];
				bpc_pkg::REG_LADDER_C:      ladder_q[2] <= cfg_data[bpc_pkg::AnalogW-1:0];
				bpc_pkg::REG_LADDER_D:      ladder_q[3] <= cfg_data[bpc_pkg::AnalogW-1:0];
				bpc_pkg::REG_DOUBLE_WINDOW: tcfg_q.double_window_ms <= cfg_data;
				bpc_pkg::REG_LONG_HOLD:     tcfg_q.long_hold_ms <= cfg_data;
				bpc_pkg::REG_RELEASE_GUARD: tcfg_q.release_guard_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	logic                          valid_s1;
	logic [bpc_pkg::TimeW-1:0]     now_s1;
	logic                          digital_s1;
	logic [bpc_pkg::AnalogW-1:0]   analog_s1;

	// The stage-1 word moves on whenever the result register is free or drains.
	logic advance;
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1     <= now_ms;
			digital_s1 <= digital_level;
			analog_s1  <= analog_level;
		end
	end

	// Released decision and press state.
	logic            released;
	bpc_pkg::event_t event_d;

	bpc_level u_level (
		.switch_mode   (tcfg_q.switch_mode),
		.ladder        (ladder_q),
		.digital_level (digital_s1),
		.analog_level  (analog_s1),
		.released      (released)
	);

	bpc_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.now_ms      (now_s1),
		.released    (released),
		.tcfg        (tcfg_q),
		.press_event (event_d)
	);

	// Result register.
	logic [1:0] event_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= event_d;
		end
	end

	assign press_event = event_q;

endmodule

// ===== rtl/bpc_checker.sv =====
// Port-level checks of the button press classifier and the bind that
// attaches them to button_press_classifier_core. Depends only on its ports.
module bpc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    press_event
);

	// A held result keeps its value until taken.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(press_event))
		else $error("result changed or vanished while stalled");

	// Backpressure on the input only when both buffer words are occupied.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	// Taking a poll while the output stalls fills the buffer.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid && !out_ready |=> !in_ready || out_ready)
		else $error("buffer did not fill under stall");

	// A fresh result follows an accepted poll through the input register and the result register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without a poll");

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.press_event (press_event)
);
